// ===== src/srig_pkg.sv =====
// shared constants for the systematic resampling index generator
// command codes, field widths and parameter defaults; no dependencies
`timescale 1ns / 1ps

package srig_pkg;

	// parameter defaults
	localparam int MAX_PARTICLES_DEF = 128;
	localparam int WEIGHT_BITS_DEF   = 32;

	// fixed field widths
	localparam int CMD_W     = 2;
	localparam int SLOT_W    = 7;
	localparam int WVAL_W    = 32;
	localparam int OFFSET_W  = 16;
	localparam int COUNT_W   = 8;
	localparam int OUT_IDX_W = 7;

	// particle count after reset
	localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd80;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd2;

endpackage

// ===== src/srig_mul.sv =====
// shared multiplier of the index generator, product registered
// depends on srig_pkg for the width of the second operand
`timescale 1ns / 1ps

module srig_mul #(
	parameter int A_W = 40
) (
	input  logic                                   clk,
	input  logic [A_W-1:0]                         op_a,
	input  logic [srig_pkg::OFFSET_W-1:0]          op_b,
	output logic [A_W+srig_pkg::OFFSET_W-1:0]      prod_q
);
	import srig_pkg::*;

	localparam int PROD_W = A_W + OFFSET_W;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

endmodule

// ===== src/systematic_resample_index_gen.sv =====
// systematic resampling index generator: weight store, pass sequencer and walk
// depends on srig_pkg and srig_mul (shared multiplier)
`timescale 1ns / 1ps

// usage
// - input transfer: start high while busy is low; cmd selects the operation
//   load (cmd 0): slot/weight_value go into the weight store, busy stays low
//   start (cmd 1): latches count and offset_fraction, then sums the weights of
//   slots 0 .. count-1 through the single read port of the store; busy until
//   the pass is ready for draws
//   draw (cmd 2): walks the pointer forward until the scaled cumulative weight
//   reaches the target or the pointer is on the last slot of the pass; each slot
//   stepped takes a store read, the shared multiplier and an accumulate, then a
//   new compare; result strobe in the cycle after the final compare
// - result transfer: result_stb high for one cycle with chosen_index and
//   last_draw; the receiver cannot stall, so results never wait
// - a draw with no pass running gives no result and leaves busy low
// - configuration: cfg_wr_en writes particle_count; it is used from the next start
// - reset: sequencer idle, no pass running, particle_count back to 80;
//   weight store contents are undefined until loaded
module systematic_resample_index_gen #(
	parameter int MAX_PARTICLES = srig_pkg::MAX_PARTICLES_DEF,
	parameter int WEIGHT_BITS   = srig_pkg::WEIGHT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [srig_pkg::CMD_W-1:0]        cmd,
	input  logic [srig_pkg::SLOT_W-1:0]       slot,
	input  logic [srig_pkg::WVAL_W-1:0]       weight_value,
	input  logic [srig_pkg::OFFSET_W-1:0]     offset_fraction,
	input  logic                              cfg_wr_en,
	input  logic [srig_pkg::COUNT_W-1:0]      cfg_wr_data,
	output logic                              result_stb,
	output logic [srig_pkg::OUT_IDX_W-1:0]    chosen_index,
	output logic                              last_draw
);
	import srig_pkg::*;

	localparam int IDX_W  = $clog2(MAX_PARTICLES);
	localparam int SUM_W  = WEIGHT_BITS + COUNT_W;      // total of up to 255 weights
	localparam int LHS_W  = SUM_W + COUNT_W;            // running sum times count
	localparam int CMP_W  = LHS_W + OFFSET_W;           // both sides of the compare
	localparam int PROD_W = SUM_W + OFFSET_W;
	localparam int CAP    = (MAX_PARTICLES < 255) ? MAX_PARTICLES : 255;
	localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAP);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MULU,
		ST_TGT,
		ST_LHS0,
		ST_CMP,
		ST_MULW,
		ST_ACC
	} state_t;

	state_t state_q;

	logic [COUNT_W-1:0]     particle_count_q;
	logic [COUNT_W-1:0]     pc_q;          // count latched at start
	logic [COUNT_W-1:0]     k_q;           // summing address
	logic                   rd_pend_q;     // store read in flight during the sum
	logic [COUNT_W-1:0]     ptr_q;         // walk pointer
	logic [COUNT_W-1:0]     draw_q;        // draws done in this pass
	logic [OFFSET_W-1:0]    u_q;
	logic                   uniform_q;
	logic                   pass_active_q;
	logic [SUM_W-1:0]       total_q;
	logic [LHS_W-1:0]       lhs_q;         // running sum times count
	logic [CMP_W-1:0]       target_q;      // (draw * 65536 + u) * total

	logic [WEIGHT_BITS-1:0] mem [MAX_PARTICLES];
	logic [WEIGHT_BITS-1:0] rd_data_q;
	logic [IDX_W-1:0]       rd_addr;

	logic                   accept;
	logic                   load_wr;
	logic [COUNT_W-1:0]     c_sat;
	logic [COUNT_W-1:0]     ptr_nxt;
	logic                   step;
	logic [SUM_W-1:0]       mul_a;
	logic [OFFSET_W-1:0]    mul_b;
	logic [PROD_W-1:0]      prod_q;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign load_wr = accept && (cmd == CMD_LOAD) && (32'(slot) < MAX_PARTICLES);

	// count of the pass, saturated to 1 .. store depth, at most 255
	always_comb begin
		if (particle_count_q == '0)
			c_sat = COUNT_W'(1);
		else if (particle_count_q > CAP_CNT)
			c_sat = CAP_CNT;
		else
			c_sat = particle_count_q;
	end

	assign ptr_nxt = ptr_q + COUNT_W'(1);

	// walk on while the scaled cumulative weight is below the target and slots remain
	assign step = ({lhs_q, {OFFSET_W{1'b0}}} < target_q) && (ptr_nxt < pc_q);

	// store read address
	always_comb begin
		case (state_q)
			ST_SUM:  rd_addr = IDX_W'(k_q);
			ST_CMP:  rd_addr = IDX_W'(ptr_nxt);
			default: rd_addr = '0;
		endcase
	end

	// shared multiplier: offset times total, or weight (1 if even spread) times count
	always_comb begin
		case (state_q)
			ST_MULU: begin
				mul_a = total_q;
				mul_b = u_q;
			end
			default: begin
				mul_a = uniform_q ? SUM_W'(1) : SUM_W'(rd_data_q);
				mul_b = OFFSET_W'(pc_q);
			end
		endcase
	end

	srig_mul #(
		.A_W (SUM_W)
	) u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	// weight store
	always_ff @(posedge clk) begin
		if (load_wr)
			mem[IDX_W'(slot)] <= weight_value[WEIGHT_BITS-1:0];
		rd_data_q <= mem[rd_addr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			particle_count_q <= COUNT_RESET;
		else if (cfg_wr_en)
			particle_count_q <= cfg_wr_data;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pc_q          <= '0;
			k_q           <= '0;
			rd_pend_q     <= 1'b0;
			ptr_q         <= '0;
			draw_q        <= '0;
			u_q           <= '0;
			uniform_q     <= 1'b0;
			pass_active_q <= 1'b0;
			total_q       <= '0;
			lhs_q         <= '0;
			target_q      <= '0;
			result_stb    <= 1'b0;
			chosen_index  <= '0;
			last_draw     <= 1'b0;
		end else begin
			// strobe follows the final compare of a draw
			result_stb <= (state_q == ST_CMP) && !step;
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd == CMD_START) begin
						pc_q          <= c_sat;
						u_q           <= offset_fraction;
						uniform_q     <= 1'b0;
						pass_active_q <= 1'b0;
						total_q       <= '0;
						ptr_q         <= '0;
						draw_q        <= '0;
						k_q           <= '0;
						rd_pend_q     <= 1'b0;
						state_q       <= ST_SUM;
					end else if (accept && cmd == CMD_DRAW) begin
						if (!pass_active_q || draw_q >= pc_q)
							pass_active_q <= 1'b0;
						else
							state_q <= ST_CMP;
					end
				end
				ST_SUM: begin
					if (rd_pend_q)
						total_q <= total_q + SUM_W'(rd_data_q);
					rd_pend_q <= (k_q < pc_q);
					if (k_q < pc_q) begin
						k_q <= k_q + COUNT_W'(1);
					end else if (!rd_pend_q) begin
						// all zero weights: even spread
						if (total_q == '0) begin
							uniform_q <= 1'b1;
							total_q   <= SUM_W'(pc_q);
						end
						state_q <= ST_MULU;
					end
				end
				ST_MULU: begin
					state_q <= ST_TGT;
				end
				ST_TGT: begin
					target_q <= CMP_W'(prod_q);
					state_q  <= ST_LHS0;
				end
				ST_LHS0: begin
					lhs_q         <= LHS_W'(prod_q);
					pass_active_q <= 1'b1;
					state_q       <= ST_IDLE;
				end
				ST_CMP: begin
					if (step) begin
						ptr_q   <= ptr_nxt;
						state_q <= ST_MULW;
					end else begin
						chosen_index <= ptr_q[OUT_IDX_W-1:0];
						last_draw    <= (draw_q + COUNT_W'(1) == pc_q);
						draw_q       <= draw_q + COUNT_W'(1);
						if (draw_q + COUNT_W'(1) >= pc_q)
							pass_active_q <= 1'b0;
						target_q <= target_q +
							{{(CMP_W-SUM_W-OFFSET_W){1'b0}}, total_q, {OFFSET_W{1'b0}}};
						state_q  <= ST_IDLE;
					end
				end
				ST_MULW: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					lhs_q   <= lhs_q + LHS_W'(prod_q);
					state_q <= ST_CMP;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result only ever follows a final compare
	a_stb_after_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		result_stb |-> $past(state_q == ST_CMP))
		else $error("result strobe without a final compare");

	// the sequencer is ready again when a result is shown
	a_stb_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_stb |-> !busy)
		else $error("result strobe while busy");

	// pointer and draw count stay inside the pass
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		pass_active_q |-> (ptr_q < pc_q) && (draw_q < pc_q))
		else $error("walk pointer or draw count beyond the pass");

	// the last draw closes the pass
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_stb && last_draw) |-> !pass_active_q)
		else $error("pass still active after its last draw");

	// the pointer only moves forward by one during a walk
	a_ptr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && step) |=> (ptr_q == $past(ptr_q) + COUNT_W'(1)))
		else $error("walk pointer did not advance by one");

endmodule

// ===== tb/sv/tb_systematic_resample_index_gen.sv =====
`timescale 1ns / 1ps
// self-checking testbench for systematic_resample_index_gen: a directed table, then random passes
// of weight loads, a start and a run of draws; depends on srig_pkg and the block's rtl

module tb_systematic_resample_index_gen;
	import srig_pkg::*;

	localparam int          MAX_P        = MAX_PARTICLES_DEF;
	localparam int          RANDOM_ITEMS = 1800;
	// a draw with nothing to return never raises busy; this drain after busy drops covers it
	localparam int          DRAIN_CYCLES = 8;
	localparam int          END_WAIT     = 2000;
	// bound on the slowest honest run: one full walk per pass plus summing
	localparam int unsigned CYCLE_LIMIT  = 2000000;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int          PLAN_LEN     = 24;

	// where the expectation for a directed row comes from
	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} exp_kind_t;
	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
	// how the weights of a random pass are laid out
	typedef enum logic [2:0] {
		SHAPE_ZERO, SHAPE_FULL, SHAPE_TINY, SHAPE_SPARSE, SHAPE_MAX, SHAPE_TOUCH
	} weight_shape_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [CMD_W-1:0]    op;
		logic [SLOT_W-1:0]   at;
		logic [WVAL_W-1:0]   wv;     // weight, or the count for a config row
		logic [OFFSET_W-1:0] off;
		exp_kind_t           ek;
		logic [OUT_IDX_W-1:0] idx;
		logic                last;
	} plan_row_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] idx;
		logic                 last;
	} pick_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [CMD_W-1:0]      cmd;
	logic [SLOT_W-1:0]     slot;
	logic [WVAL_W-1:0]     weight_value;
	logic [OFFSET_W-1:0]   offset_fraction;
	logic                  cfg_wr_en;
	logic [COUNT_W-1:0]    cfg_wr_data;
	logic                  result_stb;
	logic [OUT_IDX_W-1:0]  chosen_index;
	logic                  last_draw;

	// expectation that travels with the item on the input side
	exp_kind_t             tag_kind = EXP_MODEL;
	logic [OUT_IDX_W-1:0]  tag_idx  = '0;
	logic                  tag_last = 1'b0;

	systematic_resample_index_gen i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.slot            (slot),
		.weight_value    (weight_value),
		.offset_fraction (offset_fraction),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.result_stb      (result_stb),
		.chosen_index    (chosen_index),
		.last_draw       (last_draw)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor state, at its reset values
	// ------------------------------------------------------------------
	logic [WVAL_W-1:0]   wt_store [MAX_P];
	logic [63:0]         sum_total   = '0;   // latched at start, or the count in even mode
	logic [63:0]         cum_weight  = '0;   // cumulative weight up to and including walk_at
	int unsigned         walk_at     = 0;
	int unsigned         draws_done  = 0;
	int unsigned         pass_len    = 0;
	logic [OFFSET_W-1:0] pass_offset = '0;
	bit                  pass_on     = 1'b0;
	bit                  even_mode   = 1'b0;
	logic [COUNT_W-1:0]  count_reg   = COUNT_RESET;

	pick_t               pending_picks [$];
	bit                  loaded [MAX_P];     // slots the stimulus has written so far
	bit                  gappy = 1'b0;

	int unsigned         err_count    = 0;
	int unsigned         work_items   = 0;
	int unsigned         results_seen = 0;
	int unsigned         passes       = 0;
	int unsigned         even_passes  = 0;
	int unsigned         cycles       = 0;

	function automatic logic [63:0] slot_wt(input int unsigned k);
		if (even_mode)
			return 64'd1;
		return {32'd0, wt_store[k]};
	endfunction

	// advance the predictor by one accepted item; hit says whether a result follows
	function automatic void model_item(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic [WVAL_W-1:0] w, input logic [OFFSET_W-1:0] u,
			output bit hit, output logic [OUT_IDX_W-1:0] idx, output bit fin);
		logic [63:0] aim;
		logic [63:0] step_no;
		logic [63:0] len64;
		int unsigned k;
		hit = 1'b0;
		idx = '0;
		fin = 1'b0;
		case (c)
			CMD_LOAD: begin
				wt_store[s] = w;
			end
			CMD_START: begin
				// count of zero acts as one, counts past the store saturate
				if (count_reg == 0)
					pass_len = 1;
				else if (count_reg > MAX_P)
					pass_len = MAX_P;
				else
					pass_len = {24'd0, count_reg};
				even_mode = 1'b0;
				sum_total = '0;
				for (k = 0; k < pass_len; k++)
					sum_total += slot_wt(k);
				// all-zero weights fall back to an even spread
				if (sum_total == 0) begin
					even_mode = 1'b1;
					sum_total = 64'(pass_len);
				end
				pass_offset = u;
				walk_at     = 0;
				cum_weight  = slot_wt(0);
				draws_done  = 0;
				pass_on     = 1'b1;
			end
			CMD_DRAW: begin
				if (!pass_on || draws_done >= pass_len) begin
					pass_on = 1'b0;
				end else begin
					step_no = 64'(draws_done);
					len64   = 64'(pass_len);
					// normalised compare with both sides scaled up, no division
					aim = (step_no * 64'd65536 + {48'd0, pass_offset}) * sum_total;
					while (cum_weight * len64 * 64'd65536 < aim && walk_at + 1 < pass_len) begin
						walk_at++;
						cum_weight += slot_wt(walk_at);
					end
					hit = 1'b1;
					idx = walk_at[OUT_IDX_W-1:0];
					fin = (draws_done + 1 == pass_len);
					draws_done++;
					if (draws_done >= pass_len)
						pass_on = 1'b0;
				end
			end
			default: ;  // unused command is ignored
		endcase
	endfunction

	// ------------------------------------------------------------------
	// scoreboard: everything sampled at the rising edge, before the block updates
	// ------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		bit                   hit;
		bit                   fin;
		logic [OUT_IDX_W-1:0] idx_p;
		pick_t                want;
		if (arst_n) begin
			if (cfg_wr_en)
				count_reg = cfg_wr_data;
			// input transfer
			if (start && busy === 1'b0) begin
				model_item(cmd, slot, weight_value, offset_fraction, hit, idx_p, fin);
				if (cmd == CMD_LOAD || cmd == CMD_START || hit)
					work_items++;
				if (cmd == CMD_START) begin
					passes++;
					if (even_mode)
						even_passes++;
				end
				case (tag_kind)
					EXP_ONE: begin
						want.idx  = tag_idx;
						want.last = tag_last;
						pending_picks = {pending_picks, want};
					end
					EXP_MODEL: begin
						if (hit) begin
							want.idx  = idx_p;
							want.last = fin;
							pending_picks = {pending_picks, want};
						end
					end
					default: ;
				endcase
			end
			// result transfer, which the testbench cannot hold off
			if (result_stb === 1'b1) begin
				results_seen++;
				if (pending_picks.size() == 0) begin
					err_count++;
					$error("unexpected result: chosen_index %0d, last_draw %0b",
						chosen_index, last_draw);
				end else begin
					want = pending_picks.pop_front();
					if (chosen_index !== want.idx) begin
						err_count++;
						$error("chosen_index: expected %0d, actual %0d", want.idx, chosen_index);
					end
					if (last_draw !== want.last) begin
						err_count++;
						$error("last_draw: expected %0b, actual %0b", want.last, last_draw);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// driving: inputs move only at the falling edge
	// ------------------------------------------------------------------

	// one input transfer; returns at the falling edge after it was taken, start still high
	task automatic send(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic [WVAL_W-1:0] w, input logic [OFFSET_W-1:0] u, input int unsigned gap,
			input exp_kind_t ek, input logic [OUT_IDX_W-1:0] ei, input logic el);
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd             = c;
		slot            = s;
		weight_value    = w;
		offset_fraction = u;
		tag_kind        = ek;
		tag_idx         = ei;
		tag_last        = el;
		start           = 1'b1;
		if (c == CMD_LOAD)
			loaded[s] = 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random-phase transfer, checked against the predictor
	task automatic feed(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic [WVAL_W-1:0] w, input logic [OFFSET_W-1:0] u);
		send(c, s, w, u, gappy ? $urandom_range(0, 8) : 0, EXP_MODEL, '0, 1'b0);
	endtask

	// block idle: nothing owed, busy low, and a drain for any draw that owes nothing
	task automatic settle();
		start = 1'b0;
		repeat (2) @(negedge clk);
		while (pending_picks.size() != 0 || busy !== 1'b0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] v);
		settle();
		cfg_wr_data = v;
		cfg_wr_en   = 1'b1;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	function automatic logic [OFFSET_W-1:0] pick_offset();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return OFFSET_W'($urandom);
	endfunction

	// mostly small passes so many of them fit; a few large and out-of-range counts
	function automatic logic [COUNT_W-1:0] pick_count();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return COUNT_W'($urandom_range(1, 8));
		if (roll < 90)
			return COUNT_W'($urandom_range(9, 40));
		if (roll < 96)
			return COUNT_W'($urandom_range(41, 128));
		if (roll < 99)
			return COUNT_W'($urandom_range(129, 255));
		return '0;
	endfunction

	// one well-formed pass: set the count, lay out weights, start, draw to the end and up to two past it,
	// with loads, restarts and unused commands sprinkled in
	task automatic random_pass(input logic [COUNT_W-1:0] cv);
		int unsigned   eff;
		int unsigned   n;
		int unsigned   k;
		int unsigned   roll;
		weight_shape_t shape;
		logic [WVAL_W-1:0] w;
		write_count(cv);
		eff   = (cv == 0) ? 1 : (cv > MAX_P) ? MAX_P : {24'd0, cv};
		gappy = ($urandom_range(0, 2) != 0);
		shape = weight_shape_t'($urandom_range(0, 5));
		if (shape == SHAPE_TOUCH) begin
			n = $urandom_range(0, 6);
			repeat (n)
				feed(CMD_LOAD, SLOT_W'($urandom), $urandom, OFFSET_W'($urandom));
		end else begin
			for (k = 0; k < eff; k++) begin
				case (shape)
					SHAPE_ZERO:   w = '0;
					SHAPE_FULL:   w = $urandom;
					SHAPE_TINY:   w = $urandom_range(0, 15);
					SHAPE_SPARSE: w = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
					default:      w = '1;
				endcase
				feed(CMD_LOAD, k[SLOT_W-1:0], w, OFFSET_W'($urandom));
			end
		end
		// the walk must never meet a slot that was never loaded
		for (k = 0; k < eff; k++)
			if (!loaded[k])
				feed(CMD_LOAD, k[SLOT_W-1:0], $urandom, OFFSET_W'($urandom));
		// a little noise ahead of the start
		if ($urandom_range(0, 9) == 0)
			feed(CMD_UNUSED, SLOT_W'($urandom), $urandom, OFFSET_W'($urandom));
		if ($urandom_range(0, 9) == 0)
			feed(CMD_DRAW, SLOT_W'($urandom), $urandom, OFFSET_W'($urandom));
		feed(CMD_START, SLOT_W'($urandom), $urandom, pick_offset());
		n = eff + $urandom_range(0, 2);
		repeat (n) begin
			roll = $urandom_range(0, 39);
			if (roll == 0)
				feed(CMD_LOAD, SLOT_W'($urandom_range(0, eff - 1)), $urandom,
					OFFSET_W'($urandom));
			else if (roll == 1)
				feed(CMD_UNUSED, SLOT_W'($urandom), $urandom, OFFSET_W'($urandom));
			else if (roll == 2)
				feed(CMD_START, SLOT_W'($urandom), $urandom, pick_offset());
			feed(CMD_DRAW, SLOT_W'($urandom), $urandom, OFFSET_W'($urandom));
		end
	endtask

	// directed table: expectations typed in where they follow at a glance
	plan_row_t plan [PLAN_LEN] = '{
		// draw straight after reset, then the unused command: neither answers
		'{ROW_ITEM, CMD_DRAW,   7'd0,   32'd0,         16'd0,      EXP_NONE, 7'd0, 1'b0},
		'{ROW_ITEM, CMD_UNUSED, 7'd0,   32'd0,         16'd0,      EXP_NONE, 7'd0, 1'b0},
		// four zero weights: even spread, offset just under one spacing
		'{ROW_CFG,  CMD_LOAD,   7'd0,   32'd4,         16'd0,      EXP_NONE, 7'd0, 1'b0},
		'{ROW_ITEM, CMD_LOAD,   7'd0,   32'd0,         16'd0,      EXP_NONE, 7'd0, 1'b0},
		'{ROW_ITEM, CMD_LOAD,   7'd1,   32'd0,         16'd0,      EXP_NONE, 7'd0, 1'b0},
		'{ROW_ITEM, CMD_LOAD,   7'd2,   32'd0,         16'd0,      EXP_NONE, 7'd0, 1'b0},
		'{ROW_ITEM, CMD_LOAD,   7'd3,   32'd0,         16'd0,      EXP_NONE, 7'd0, 1'b0},
		'{ROW_ITEM, CMD_START,  7'd0,   32'd0,         16'hFFFF,   EXP_NONE, 7'd0, 1'b0},
		'{ROW_ITEM, CMD_DRAW,   7'd0,   32'd0,         16'd0,      EXP_ONE,  7'd0, 1'b0},
		'{ROW_ITEM, CMD_DRAW,   7'd0,   32'd0,         16'd0,      EXP_ONE,  7'd1, 1'b0},
		'{ROW_ITEM, CMD_DRAW,   7'd0,   32'd0,         16'd0,      EXP_ONE,  7'd2, 1'b0},
		'{ROW_ITEM, CMD_DRAW,   7'd0,   32'd0,         16'd0,      EXP_ONE,  7'd3, 1'b1},
		// one draw too many
		'{ROW_ITEM, CMD_DRAW,   7'd0,   32'd0,         16'd0,      EXP_NONE, 7'd0, 1'b0},
		// all weight on slot 0 at full scale, top slot loaded too but outside the pass
		'{ROW_ITEM, CMD_LOAD,   7'd0,   32'hFFFF_FFFF, 16'd0,      EXP_NONE, 7'd0, 1'b0},
		'{ROW_ITEM, CMD_LOAD,   7'd127, 32'hFFFF_FFFF, 16'd0,      EXP_NONE, 7'd0, 1'b0},
		'{ROW_ITEM, CMD_START,  7'd0,   32'd0,         16'd0,      EXP_NONE, 7'd0, 1'b0},
		'{ROW_ITEM, CMD_DRAW,   7'd0,   32'd0,         16'd0,      EXP_ONE,  7'd0, 1'b0},
		'{ROW_ITEM, CMD_DRAW,   7'd0,   32'd0,         16'd0,      EXP_ONE,  7'd0, 1'b0},
		'{ROW_ITEM, CMD_DRAW,   7'd0,   32'd0,         16'd0,      EXP_ONE,  7'd0, 1'b0},
		'{ROW_ITEM, CMD_DRAW,   7'd0,   32'd0,         16'd0,      EXP_ONE,  7'd0, 1'b1},
		// count of zero behaves as a single particle
		'{ROW_CFG,  CMD_LOAD,   7'd0,   32'd0,         16'd0,      EXP_NONE, 7'd0, 1'b0},
		'{ROW_ITEM, CMD_START,  7'd0,   32'd0,         16'h3039,   EXP_NONE, 7'd0, 1'b0},
		'{ROW_ITEM, CMD_DRAW,   7'd0,   32'd0,         16'd0,      EXP_ONE,  7'd0, 1'b1},
		'{ROW_ITEM, CMD_DRAW,   7'd0,   32'd0,         16'd0,      EXP_NONE, 7'd0, 1'b0}
	};

	initial begin : stimulus
		int unsigned r;
		int unsigned goal;
		int unsigned waited;
		logic [COUNT_W-1:0] cv;
		arst_n          = 1'b0;
		start           = 1'b0;
		cmd             = CMD_LOAD;
		slot            = '0;
		weight_value    = '0;
		offset_fraction = '0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		for (r = 0; r < PLAN_LEN; r++) begin
			if (plan[r].kind == ROW_CFG)
				write_count(plan[r].wv[COUNT_W-1:0]);
			else
				send(plan[r].op, plan[r].at, plan[r].wv, plan[r].off, 0, plan[r].ek,
					plan[r].idx, plan[r].last);
		end

		// random part: the first passes take the count extremes, then random counts
		settle();
		goal = work_items + RANDOM_ITEMS;
		r    = 0;
		while (work_items < goal) begin
			case (r)
				0:       cv = 8'd128;
				1:       cv = 8'd255;
				2:       cv = 8'd1;
				default: cv = pick_count();
			endcase
			random_pass(cv);
			r++;
		end

		// wind down: wait out anything still owed, bounded
		start  = 1'b0;
		waited = 0;
		while (pending_picks.size() != 0 && waited < END_WAIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_picks.size() != 0) begin
			err_count++;
			$error("%0d expected results never arrived", pending_picks.size());
		end

		$display("checked %0d results over %0d passes from %0d load, start and draw transfers",
			results_seen, passes, work_items);
		$display("%0d of those passes had all-zero weights and ran as an even spread",
			even_passes);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
